// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL files of the decimal text converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/dtoi_pkg.sv =====
// Types and constants for the decimal text to integer unit.
package dtoi_pkg;

   // One input character with its start marker.
   typedef struct packed {
      logic [7:0] ch;
      logic       start_of_text;
   } req_type;

   // One parsed number.
   typedef struct packed {
      logic [31:0] number;
      logic        no_digits;
      logic        was_negative;
   } rsp_type;

   // Parser phase, one-hot.
   typedef enum logic [2:0] {
      PH_DONE   = 3'b001,
      PH_SKIP   = 3'b010,
      PH_DIGITS = 3'b100
   } phase_type;

   // Sign seen so far.
   typedef enum logic [1:0] {
      SG_NONE = 2'b00,
      SG_POS  = 2'b01,
      SG_NEG  = 2'b10
   } sign_type;

   localparam logic [31:0] NO_NUMBER = 32'hFFFF_FFFF;
   localparam logic [7:0]  CH_SPACE  = 8'h20;
   localparam logic [7:0]  CH_EQUAL  = 8'h3D;
   localparam logic [7:0]  CH_COLON  = 8'h3A;
   localparam logic [7:0]  CH_MINUS  = 8'h2D;
   localparam logic [7:0]  CH_ZERO   = 8'h30;
   localparam logic [7:0]  CH_NINE   = 8'h39;

endpackage

// ===== rtl/core/dtoi_parse.sv =====
// Parser stage: phase, sign and accumulator state plus the per-character step.
`include "assert_macros.svh"

module dtoi_parse (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_fire,
   input  dtoi_pkg::req_type item,
   output logic             emit,
   output dtoi_pkg::rsp_type result
);

   dtoi_pkg::phase_type phase_ff, phase_in, phase_cur;
   dtoi_pkg::sign_type  sign_ff, sign_in, sign_cur;
   logic [31:0]         acc_ff, acc_in, acc_cur;
   logic                is_digit, is_skip, is_minus, in_digits;
   logic [3:0]          digit_val;
   logic [7:0]          ch_off;

   // Character classes
   assign is_digit  = (item.ch >= dtoi_pkg::CH_ZERO) && (item.ch <= dtoi_pkg::CH_NINE);
   assign is_skip   = (item.ch == dtoi_pkg::CH_SPACE) || (item.ch == dtoi_pkg::CH_EQUAL)
                      || (item.ch == dtoi_pkg::CH_COLON);
   assign is_minus  = (item.ch == dtoi_pkg::CH_MINUS);
   assign ch_off    = item.ch - dtoi_pkg::CH_ZERO;
   assign digit_val = ch_off[3:0];

   // Start marker reopens the parse with cleared state
   assign phase_cur = item.start_of_text ? dtoi_pkg::PH_SKIP : phase_ff;
   assign sign_cur  = item.start_of_text ? dtoi_pkg::SG_NONE : sign_ff;
   assign acc_cur   = item.start_of_text ? 32'd0 : acc_ff;

   // Step logic for one character
   always_comb begin
      phase_in  = phase_cur;
      sign_in   = sign_cur;
      acc_in    = acc_cur;
      emit      = 1'b0;
      in_digits = 1'b0;
      unique case (phase_cur)
         dtoi_pkg::PH_SKIP: begin
            if (is_minus) begin
               sign_in  = dtoi_pkg::SG_NEG;
               phase_in = dtoi_pkg::PH_DIGITS;
            end else if (!is_skip) begin
               in_digits = 1'b1;
            end
         end
         dtoi_pkg::PH_DIGITS: begin
            in_digits = 1'b1;
         end
         dtoi_pkg::PH_DONE: begin
            in_digits = 1'b0;
         end
         default: begin
            in_digits = 1'b0;
         end
      endcase
      if (in_digits) begin
         if (is_digit) begin
            phase_in = dtoi_pkg::PH_DIGITS;
            if (sign_cur == dtoi_pkg::SG_NONE) begin
               sign_in = dtoi_pkg::SG_POS;
            end
            // acc*10 as two shifted adds, wraps at 32 bits
            acc_in = {acc_cur[28:0], 3'b000} + {acc_cur[30:0], 1'b0} + {28'd0, digit_val};
         end else begin
            emit     = 1'b1;
            phase_in = dtoi_pkg::PH_DONE;
         end
      end
   end

   // Result formatting from the sign seen
   always_comb begin
      unique case (sign_cur)
         dtoi_pkg::SG_NEG: begin
            result.number       = 32'd0 - acc_cur;
            result.no_digits    = 1'b0;
            result.was_negative = 1'b1;
         end
         dtoi_pkg::SG_POS: begin
            result.number       = acc_cur;
            result.no_digits    = 1'b0;
            result.was_negative = 1'b0;
         end
         default: begin
            result.number       = dtoi_pkg::NO_NUMBER;
            result.no_digits    = 1'b1;
            result.was_negative = 1'b0;
         end
      endcase
   end

   // State registers, updated on each character that moves through
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dtoi_pkg::PH_DONE;
         sign_ff  <= dtoi_pkg::SG_NONE;
         acc_ff   <= 32'd0;
      end else if (step_fire) begin
         phase_ff <= phase_in;
         sign_ff  <= sign_in;
         acc_ff   <= acc_in;
      end
   end

   `ASSERT_RST(a_phase_onehot, clock, reset, $onehot(phase_ff), "phase lost one-hot code")
   `ASSERT_RST(a_emit_closes, clock, reset,
      (step_fire && emit) |=> (phase_ff == dtoi_pkg::PH_DONE), "emit did not close number")
   `ASSERT_RST(a_digit_sets_sign, clock, reset,
      (step_fire && in_digits && is_digit) |=> (sign_ff != dtoi_pkg::SG_NONE),
      "digit left sign unset")

endmodule

// ===== rtl/core/dtoi_rsp_buf.sv =====
// Result register holding one parsed number until the consumer takes it.
module dtoi_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  dtoi_pkg::rsp_type load_data,
   output logic              can_load,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dtoi_pkg::rsp_type rsp_payload
);

   logic              valid_ff, valid_in;
   dtoi_pkg::rsp_type data_ff;

   // Free when empty or being drained this cycle
   assign can_load = !valid_ff || rsp_ready;
   assign valid_in = load ? 1'b1 : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

// ===== rtl/core/decimal_text_to_integer_unit.sv =====
// Top level: input register, parser stage and result register.
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_ready | req_payload (ch, start_of_text)
//   rsp_    | out       | rsp_valid/rsp_ready | rsp_payload (number, no_digits, was_negative)
//
// One character per cycle is taken when the result side keeps up.
// rsp_valid rises once the character ending the number has left the input register
// and its result is loaded into the result register; a held result can delay that load.
// Sign formatting sits between those registers; multiply-by-ten and add feed the accumulator.
// A held result stalls the parser stage; req_ready drops while a full input register stalls.
// Reset clears the parser to waiting for a start marker and empties both registers.
`include "assert_macros.svh"

module decimal_text_to_integer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dtoi_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dtoi_pkg::rsp_type rsp_payload
);

   logic              in_valid_ff, in_valid_in;
   dtoi_pkg::req_type in_data_ff;
   logic              step_fire, can_load, emit, load;
   dtoi_pkg::rsp_type result;

   // Input register advances whenever the result side can absorb a result
   assign step_fire   = in_valid_ff && can_load;
   assign req_ready   = !in_valid_ff || step_fire;
   assign in_valid_in = (req_valid && req_ready) ? 1'b1 : (in_valid_ff && !step_fire);
   assign load        = step_fire && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
   end

   dtoi_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step_fire (step_fire),
      .item      (in_data_ff),
      .emit      (emit),
      .result    (result)
   );

   dtoi_rsp_buf u_rsp_buf (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .load_data   (result),
      .can_load    (can_load),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   `ASSERT_RST(a_no_overwrite, clock, reset, !(load && rsp_valid && !rsp_ready),
      "result register overwritten while held")
   `ASSERT_ALWAYS(a_ready_when_empty, clock, !in_valid_ff |-> req_ready,
      "input register empty but not ready")

endmodule
